// ===== src/wsf_pkg.sv =====
package wsf_pkg;

   // defaults for the top level parameters
   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int PIXEL_BITS_DEFAULT = 14;

   // width register
   localparam int CFG_BITS       = 11;
   localparam int WIDTH_MIN      = 3;
   localparam int WIDTH_AT_RESET = 1024;

   // filter arithmetic
   localparam int CENTER_WEIGHT = 2;
   localparam int DIVISOR       = 10;

   // window control from the top level stage flow logic
   typedef struct packed {
      logic clear;     // drop both stored columns
      logic shift;     // move the current column into the window
      logic load_sum;  // register the weighted sum
   } win_ctrl_type;

endpackage

// ===== src/wsf_pixel_if.sv =====
interface wsf_pixel_if #(
   parameter int PIXEL_BITS = wsf_pkg::PIXEL_BITS_DEFAULT
) ();
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

// ===== src/wsf_result_if.sv =====
interface wsf_result_if #(
   parameter int PIXEL_BITS = wsf_pkg::PIXEL_BITS_DEFAULT
) ();
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] filtered_value;
   logic                  frame_last;

   modport source (output valid, output filtered_value, output frame_last, input ready);
   modport sink   (input valid, input filtered_value, input frame_last, output ready);
endinterface

// ===== src/wsf_line_mem.sv =====
module wsf_line_mem #(
   parameter int DEPTH     = wsf_pkg::MAX_WIDTH_DEFAULT,
   parameter int ADDR_BITS = $clog2(DEPTH),
   parameter int DATA_BITS = 2 * wsf_pkg::PIXEL_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/wsf_window.sv =====
module wsf_window #(
   parameter int PIXEL_BITS = wsf_pkg::PIXEL_BITS_DEFAULT,
   parameter int SUM_BITS   = wsf_pkg::PIXEL_BITS_DEFAULT + 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wsf_pkg::win_ctrl_type ctrl,
   input  logic [PIXEL_BITS-1:0] up,
   input  logic [PIXEL_BITS-1:0] mid,
   input  logic [PIXEL_BITS-1:0] cur,
   output logic [SUM_BITS-1:0]   sum
);

   // oldest column and previous column of the 3x3 window
   logic [PIXEL_BITS-1:0] old_up_ff, old_mid_ff, old_cur_ff;
   logic [PIXEL_BITS-1:0] prv_up_ff, prv_mid_ff, prv_cur_ff;
   logic [SUM_BITS-1:0]   sum_ff;
   logic [SUM_BITS-1:0]   sum_in;

   // weighted sum, center of the window counted twice
   always_comb begin
      sum_in = SUM_BITS'(old_up_ff) + SUM_BITS'(old_mid_ff) + SUM_BITS'(old_cur_ff)
             + SUM_BITS'(prv_up_ff) + SUM_BITS'(prv_cur_ff)
             + SUM_BITS'(wsf_pkg::CENTER_WEIGHT) * SUM_BITS'(prv_mid_ff)
             + SUM_BITS'(up) + SUM_BITS'(mid) + SUM_BITS'(cur);
   end

   // column shift register
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         old_up_ff  <= '0;
         old_mid_ff <= '0;
         old_cur_ff <= '0;
         prv_up_ff  <= '0;
         prv_mid_ff <= '0;
         prv_cur_ff <= '0;
      end else if (ctrl.shift) begin
         old_up_ff  <= prv_up_ff;
         old_mid_ff <= prv_mid_ff;
         old_cur_ff <= prv_cur_ff;
         prv_up_ff  <= up;
         prv_mid_ff <= mid;
         prv_cur_ff <= cur;
      end
   end

   // sum stage register
   always_ff @(posedge clock) begin
      if (ctrl.load_sum) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// ===== src/weighted_3x3_smoothing_filter.sv =====
// 3x3 weighted smoothing filter for a streamed square image.
// req_bus carries one pixel per transaction in row-major order; rsp_bus
// carries one filtered_value per interior pixel, frame_last marking the
// final one of a frame. csr_write_en/csr_write_data set the image side
// (values below 3 act as 3, above MAX_WIDTH as MAX_WIDTH) and restart the
// frame; write it only while the block is idle.
// The result for pixel (r-1, c-1) belongs to the transaction of pixel
// (r, c); it passes the read stage (line memory read at the accepting
// edge), the sum stage register and the divide by ten into the output register.
// Throughput is one pixel per cycle while the receiver does not stall, set by
// the single-port-per-direction line memory (one read and one write each cycle).
// Reset sets the side to 1024 (capped at MAX_WIDTH), clears the counters,
// window and pipeline. The line memory is not cleared and needs no
// clearing pass; its stale entries only feed the first two rows, which
// give no result.
// When the receiver stalls the output register holds its transaction; input is
// accepted until the sum stage is full and the read stage holds an interior pixel.
module weighted_3x3_smoothing_filter #(
   parameter int MAX_WIDTH  = wsf_pkg::MAX_WIDTH_DEFAULT,
   parameter int PIXEL_BITS = wsf_pkg::PIXEL_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   wsf_pixel_if.sink                     req_bus,
   wsf_result_if.source                  rsp_bus,
   input  logic                          csr_write_en,
   input  logic [wsf_pkg::CFG_BITS-1:0]  csr_write_data
);

   localparam int CNT_BITS   = $clog2(MAX_WIDTH);
   localparam int SUM_BITS   = PIXEL_BITS + 4;
   localparam int DIV_SHIFT  = SUM_BITS + 4;
   localparam longint unsigned DIV_MULT =
      ((64'd1 << DIV_SHIFT) + 64'(wsf_pkg::DIVISOR) - 64'd1) / 64'(wsf_pkg::DIVISOR);
   localparam int MULT_BITS  = DIV_SHIFT - 3;
   localparam int PROD_BITS  = SUM_BITS + MULT_BITS;
   localparam int RESET_SIDE = (wsf_pkg::WIDTH_AT_RESET < MAX_WIDTH) ?
                               wsf_pkg::WIDTH_AT_RESET : MAX_WIDTH;

   // width and position
   logic [CNT_BITS-1:0] last_ff, last_in;
   logic [CNT_BITS-1:0] col_ff, row_ff;

   // read stage
   logic                  s1_valid_ff;
   logic [PIXEL_BITS-1:0] px1_ff;
   logic [CNT_BITS-1:0]   addr1_ff;
   logic                  emit1_ff, last1_ff;

   // sum stage
   logic s2_valid_ff, last2_ff;
   logic [SUM_BITS-1:0] sum2;

   // output register
   logic                  rsp_valid_ff;
   logic [PIXEL_BITS-1:0] rsp_value_ff;
   logic                  rsp_last_ff;

   logic req_fire, s1_go, s2_go, s1_free, s2_free, s3_free;
   logic emit_in, last_pix_in;
   logic [2*PIXEL_BITS-1:0] rd_data;
   logic [PIXEL_BITS-1:0]   mem_up, mem_mid;
   logic [PROD_BITS-1:0]    prod;
   wsf_pkg::win_ctrl_type   win_ctrl;

   // stage flow, each stage moves when the next one has room
   assign s3_free  = !rsp_valid_ff || rsp_bus.ready;
   assign s2_go    = s2_valid_ff && s3_free;
   assign s2_free  = !s2_valid_ff || s3_free;
   assign s1_go    = s1_valid_ff && (!emit1_ff || s2_free);
   assign s1_free  = !s1_valid_ff || s1_go;
   assign req_bus.ready = s1_free;
   assign req_fire = req_bus.valid && s1_free;

   // clamp of the written side, kept as last column index
   always_comb begin
      if (32'(csr_write_data) < wsf_pkg::WIDTH_MIN) begin
         last_in = CNT_BITS'(wsf_pkg::WIDTH_MIN - 1);
      end else if (32'(csr_write_data) > MAX_WIDTH) begin
         last_in = CNT_BITS'(MAX_WIDTH - 1);
      end else begin
         last_in = CNT_BITS'(32'(csr_write_data) - 32'd1);
      end
   end

   // interior test and end of frame for the incoming pixel
   assign emit_in     = (row_ff >= CNT_BITS'(2)) && (col_ff >= CNT_BITS'(2));
   assign last_pix_in = (row_ff == last_ff) && (col_ff == last_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= CNT_BITS'(RESET_SIDE - 1);
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            last_ff <= last_in;
            col_ff  <= '0;
            row_ff  <= '0;
         end else if (req_fire) begin
            if (col_ff == last_ff) begin
               col_ff <= '0;
               row_ff <= (row_ff == last_ff) ? '0 : row_ff + CNT_BITS'(1);
            end else begin
               col_ff <= col_ff + CNT_BITS'(1);
            end
         end
         if (s1_free) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_go && emit1_ff;
         end
         if (s3_free) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         px1_ff   <= req_bus.pixel;
         addr1_ff <= col_ff;
         emit1_ff <= emit_in;
         last1_ff <= last_pix_in;
      end
      if (s1_go && emit1_ff) begin
         last2_ff <= last1_ff;
      end
      if (s2_go) begin
         rsp_value_ff <= prod[DIV_SHIFT +: PIXEL_BITS];
         rsp_last_ff  <= last2_ff;
      end
   end

   // two line memories packed as one word: row r-2 high, row r-1 low
   wsf_line_mem #(
      .DEPTH     (MAX_WIDTH),
      .ADDR_BITS (CNT_BITS),
      .DATA_BITS (2 * PIXEL_BITS)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_data (rd_data),
      .wr_en   (s1_go),
      .wr_addr (addr1_ff),
      .wr_data ({mem_mid, px1_ff})
   );

   assign mem_up  = rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
   assign mem_mid = rd_data[PIXEL_BITS-1:0];

   // window and weighted sum
   always_comb begin
      win_ctrl.clear    = csr_write_en;
      win_ctrl.shift    = s1_go;
      win_ctrl.load_sum = s1_go && emit1_ff;
   end

   wsf_window #(
      .PIXEL_BITS (PIXEL_BITS),
      .SUM_BITS   (SUM_BITS)
   ) u_window (
      .clock (clock),
      .reset (reset),
      .ctrl  (win_ctrl),
      .up    (mem_up),
      .mid   (mem_mid),
      .cur   (px1_ff),
      .sum   (sum2)
   );

   // divide by ten through a reciprocal, exact over the whole sum range
   assign prod = PROD_BITS'(sum2) * PROD_BITS'(DIV_MULT);

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.filtered_value = rsp_value_ff;
   assign rsp_bus.frame_last     = rsp_last_ff;

endmodule

// ===== src/wsf_checker.sv =====
module wsf_checker #(
   parameter int PIXEL_BITS = wsf_pkg::PIXEL_BITS_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [PIXEL_BITS-1:0] rsp_value,
   input logic                  rsp_last
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_last))
      else $error("result changed while stalled");

   // input back-pressure only comes from a stalled, full pipeline
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input blocked without output stall");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("pipeline not empty after reset");

   // while input is held off by back-pressure, the output register keeps a valid result
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> rsp_valid)
      else $error("result lost under back-pressure");

endmodule

bind weighted_3x3_smoothing_filter wsf_checker #(
   .PIXEL_BITS (PIXEL_BITS)
) u_wsf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_value (rsp_bus.filtered_value),
   .rsp_last  (rsp_bus.frame_last)
);

// ===== verif/weighted_3x3_smoothing_filter_tb.sv =====
module weighted_3x3_smoothing_filter_tb;

   localparam int PIX_BITS      = wsf_pkg::PIXEL_BITS_DEFAULT;
   localparam int PIX_MAX       = (1 << PIX_BITS) - 1;
   localparam int MAX_W         = wsf_pkg::MAX_WIDTH_DEFAULT;
   localparam int CFG_W         = wsf_pkg::CFG_BITS;
   localparam int RANDOM_ITEMS  = 950;
   localparam int SETTLE_CYCLES = 8;
   localparam int END_CYCLES    = 100;
   localparam int LONG_HOLD     = 400;
   localparam int HOLD_PHASE    = 5;
   localparam int CYCLE_LIMIT   = 2_000_000;

   typedef enum logic [1:0] {FILL_CONST, FILL_RANDOM, FILL_EXTREME} fill_kind_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] filtered_value;
      logic                frame_last;
   } smooth_result_type;

   // one stretch of pixels, optionally preceded by a width write
   typedef struct {
      bit                    set_width;
      logic [CFG_W-1:0]      width;
      fill_kind_type         fill;
      logic [PIX_BITS-1:0]   level;
      int                    pixels;
      bit                    known;
      logic [PIX_BITS-1:0]   known_value;
   } frame_phase_type;

   logic             clock;
   logic             reset;
   logic             csr_write_en;
   logic [CFG_W-1:0] csr_write_data;

   wsf_pixel_if  #(.PIXEL_BITS(PIX_BITS)) req_bus ();
   wsf_result_if #(.PIXEL_BITS(PIX_BITS)) rsp_bus ();

   weighted_3x3_smoothing_filter #(
      .MAX_WIDTH  (MAX_W),
      .PIXEL_BITS (PIX_BITS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // directed frames: first row at reset width, below-range width with flat
   // images across a frame boundary, an abandoned frame, an above-range width,
   // then a full mid-size frame under a long receiver hold-off
   frame_phase_type phase_plan [6] = '{
      '{1'b0, 11'd0,    FILL_RANDOM, 14'd0,     24,  1'b0, 14'd0},
      '{1'b1, 11'd0,    FILL_CONST,  14'd16383, 9,   1'b1, 14'd16383},
      '{1'b0, 11'd0,    FILL_CONST,  14'd0,     9,   1'b1, 14'd0},
      '{1'b1, 11'd2,    FILL_RANDOM, 14'd0,     4,   1'b0, 14'd0},
      '{1'b1, 11'd2047, FILL_RANDOM, 14'd0,     40,  1'b0, 14'd0},
      '{1'b1, 11'd16,   FILL_RANDOM, 14'd0,     256, 1'b0, 14'd0}
   };

   // predictor state
   logic [CFG_W-1:0]    width_setting = CFG_W'(wsf_pkg::WIDTH_AT_RESET);
   bit   [PIX_BITS-1:0] store_upper  [MAX_W];
   bit   [PIX_BITS-1:0] store_middle [MAX_W];
   bit   [PIX_BITS-1:0] window_col   [6];
   int                  col_pos;
   int                  row_pos;

   smooth_result_type expected_smooth [$];
   int                mismatch_count;
   int                cycle_count;
   bit                long_hold_due;
   bit                tx_calm;

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch: %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic int side_of(input logic [CFG_W-1:0] w);
      if (w < wsf_pkg::WIDTH_MIN) return wsf_pkg::WIDTH_MIN;
      if (w > MAX_W) return MAX_W;
      return int'(w);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [PIX_BITS-1:0] next_pixel(input fill_kind_type fill,
                                                       input logic [PIX_BITS-1:0] level);
      case (fill)
         FILL_CONST:   return level;
         FILL_EXTREME: return ($urandom_range(0, 1) != 0) ? PIX_BITS'(PIX_MAX) : '0;
         default:      return PIX_BITS'($urandom_range(0, PIX_MAX));
      endcase
   endfunction

   function automatic void restart_frame();
      foreach (window_col[i]) window_col[i] = '0;
      col_pos = 0;
      row_pos = 0;
   endfunction

   // weighted 3x3 mean of the interior pixel up and left of px
   function automatic smooth_result_type smooth_pixel(input logic [PIX_BITS-1:0] px,
                                                      output bit produced);
      int                side;
      int                c;
      int                r;
      int                sum;
      bit [PIX_BITS-1:0] up;
      bit [PIX_BITS-1:0] mid;
      smooth_result_type res;
      side = side_of(width_setting);
      c = (col_pos >= side) ? side - 1 : col_pos;
      r = (row_pos >= side) ? side - 1 : row_pos;
      up  = store_upper[c];
      mid = store_middle[c];
      store_upper[c]  = mid;
      store_middle[c] = px;
      produced = (r >= 2) && (c >= 2);
      sum = window_col[0] + window_col[1] + window_col[2] + window_col[3]
          + wsf_pkg::CENTER_WEIGHT * window_col[4] + window_col[5] + up + mid + px;
      res.filtered_value = PIX_BITS'(sum / wsf_pkg::DIVISOR);
      res.frame_last     = (r == side - 1) && (c == side - 1);
      // oldest column out, current column in
      window_col[0] = window_col[3];
      window_col[1] = window_col[4];
      window_col[2] = window_col[5];
      window_col[3] = up;
      window_col[4] = mid;
      window_col[5] = px;
      c++;
      if (c >= side) begin
         c = 0;
         r++;
         if (r >= side) r = 0;
      end
      col_pos = c;
      row_pos = r;
      return res;
   endfunction

   task automatic run_phase(input frame_phase_type ph);
      logic [PIX_BITS-1:0] px;
      smooth_result_type   res;
      bit                  produced;
      int                  gap;
      tx_calm = ($urandom_range(0, 3) == 0);
      // width writes only once the block has drained
      if (ph.set_width) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while (expected_smooth.size() != 0);
         repeat (SETTLE_CYCLES) @(posedge clock);
         csr_write_en   <= 1'b1;
         csr_write_data <= ph.width;
         @(posedge clock);
         csr_write_en <= 1'b0;
         width_setting = ph.width;
         restart_frame();
      end
      for (int n = 0; n < ph.pixels; n++) begin
         px = next_pixel(ph.fill, ph.level);
         req_bus.valid <= 1'b1;
         req_bus.pixel <= px;
         do @(posedge clock); while (!req_bus.ready);
         res = smooth_pixel(px, produced);
         if (produced) begin
            if (ph.known) res.filtered_value = ph.known_value;
            expected_smooth.push_back(res);
         end
         gap = tx_calm ? 0 : pick_gap();
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // result receiver: random stalls, calm stretches, one long hold-off
   initial begin : result_receiver
      int hold_left;
      int burst_left;
      bit calm;
      hold_left  = 0;
      burst_left = 0;
      calm       = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (burst_left == 0) begin
            calm       = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(50, 300);
         end
         burst_left--;
         if (long_hold_due) begin
            hold_left     = LONG_HOLD;
            long_hold_due = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (calm) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            hold_left = pick_gap();
            rsp_bus.ready <= (hold_left == 0);
            if (hold_left > 0) hold_left--;
         end
      end
   end

   // compare each result transaction with the oldest pending one
   always @(posedge clock) begin : result_check
      smooth_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_smooth.size() == 0) begin
            report_mismatch("result with none pending", rsp_bus.filtered_value, 0);
         end else begin
            want = expected_smooth.pop_front();
            if (rsp_bus.filtered_value !== want.filtered_value)
               report_mismatch("filtered_value", rsp_bus.filtered_value,
                               want.filtered_value);
            if (rsp_bus.frame_last !== want.frame_last)
               report_mismatch("frame_last", rsp_bus.frame_last, want.frame_last);
         end
      end
   end

   initial begin : stimulus
      frame_phase_type ph;
      int              random_pixels;
      int              side;
      int              r;
      req_bus.valid  = 1'b0;
      req_bus.pixel  = '0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      reset          = 1'b1;
      random_pixels  = 0;
      restart_frame();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed frames
      foreach (phase_plan[i]) begin
         if (i == HOLD_PHASE) long_hold_due = 1'b1;
         run_phase(phase_plan[i]);
      end

      // random frames, mostly complete ones at small widths
      while (random_pixels < RANDOM_ITEMS) begin
         ph.set_width = ($urandom_range(0, 9) != 0);
         r = $urandom_range(0, 99);
         if (!ph.set_width) ph.width = width_setting;
         else if (r < 8) ph.width = CFG_W'($urandom_range(0, 2));
         else if (r < 80) ph.width = CFG_W'($urandom_range(3, 8));
         else ph.width = CFG_W'($urandom_range(9, 20));
         side = side_of(ph.width);
         if ($urandom_range(0, 4) != 0)
            ph.pixels = side * side * ((side <= 8) ? int'($urandom_range(1, 3)) : 1);
         else
            ph.pixels = $urandom_range(1, side * side);
         case ($urandom_range(0, 3))
            0, 1:    ph.fill = FILL_RANDOM;
            2:       ph.fill = FILL_EXTREME;
            default: ph.fill = FILL_CONST;
         endcase
         case ($urandom_range(0, 3))
            0:       ph.level = '0;
            1:       ph.level = PIX_BITS'(PIX_MAX);
            default: ph.level = PIX_BITS'($urandom_range(0, PIX_MAX));
         endcase
         ph.known       = 1'b0;
         ph.known_value = '0;
         run_phase(ph);
         random_pixels += ph.pixels;
      end

      // drain and finish
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_smooth.size() != 0);
      repeat (END_CYCLES) @(posedge clock);
      if (expected_smooth.size() != 0)
         report_mismatch("results never delivered", expected_smooth.size(), 0);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
